/* rtl/crvu_pkg.sv */
`default_nettype none

package crvu_pkg;

    localparam int ITERATIONS = 30;
    localparam int TABLE_LEN  = 40;
    localparam int NUM_ITER   = (ITERATIONS > TABLE_LEN) ? TABLE_LEN : ITERATIONS;

    localparam int ANG_W   = 32;
    localparam int IN_W    = 31;
    localparam int OUT_W   = 32;
    localparam int XY_W    = 34;
    localparam int WRAP_W  = ANG_W + 2;
    localparam int FRAC_XY = 30;
    localparam int GAIN_W  = 31;
    localparam int PROD_W  = XY_W + GAIN_W;
    localparam int SH_W    = PROD_W - FRAC_XY;

    localparam logic FUNC_ROTATE = 1'b0;
    localparam logic FUNC_VECTOR = 1'b1;

    localparam logic signed [ANG_W-1:0]  PI_Q28      = ANG_W'(843314857);
    localparam logic signed [ANG_W-1:0]  HALF_PI_Q28 = ANG_W'(421657428);
    localparam logic signed [WRAP_W-1:0] PI_WRAP     = WRAP_W'(843314857);
    localparam logic signed [WRAP_W-1:0] TWO_PI_WRAP = WRAP_W'(1686629713);
    localparam logic signed [XY_W-1:0]   ONE_Q30     = XY_W'(1073741824);
    localparam logic signed [GAIN_W-1:0] GAIN_Q30    = GAIN_W'(652032874);
    localparam logic signed [PROD_W-1:0] HALF_ULP    = PROD_W'(536870912);

    typedef struct packed {
        logic                    func;
        logic                    neg;
        logic signed [XY_W-1:0]  x;
        logic signed [XY_W-1:0]  y;
        logic signed [ANG_W-1:0] z;
    } crvu_item_t;

    typedef struct packed {
        logic signed [OUT_W-1:0] sine;
        logic signed [OUT_W-1:0] cosine;
        logic signed [OUT_W-1:0] magnitude;
        logic signed [ANG_W-1:0] angle_out;
    } crvu_result_t;

    // Arctangent of 2^-i in Q4.28, rounded to nearest.
    function automatic logic signed [ANG_W-1:0] atan_entry(input int idx);
        logic signed [ANG_W-1:0] v;
        case (idx)
            0:       v = ANG_W'(210828714);
            1:       v = ANG_W'(124459457);
            2:       v = ANG_W'(65760959);
            3:       v = ANG_W'(33381290);
            4:       v = ANG_W'(16755422);
            5:       v = ANG_W'(8385879);
            6:       v = ANG_W'(4193963);
            7:       v = ANG_W'(2097109);
            8:       v = ANG_W'(1048571);
            9:       v = ANG_W'(524287);
            10:      v = ANG_W'(262144);
            11:      v = ANG_W'(131072);
            12:      v = ANG_W'(65536);
            13:      v = ANG_W'(32768);
            14:      v = ANG_W'(16384);
            15:      v = ANG_W'(8192);
            16:      v = ANG_W'(4096);
            17:      v = ANG_W'(2048);
            18:      v = ANG_W'(1024);
            19:      v = ANG_W'(512);
            20:      v = ANG_W'(256);
            21:      v = ANG_W'(128);
            22:      v = ANG_W'(64);
            23:      v = ANG_W'(32);
            24:      v = ANG_W'(16);
            25:      v = ANG_W'(8);
            26:      v = ANG_W'(4);
            27:      v = ANG_W'(2);
            28:      v = ANG_W'(1);
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

/* rtl/crvu_prep.sv */
`default_nettype none

module crvu_prep
    import crvu_pkg::*;
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    advance,
    input  wire logic                    in_vld,
    input  wire logic                    func,
    input  wire logic signed [ANG_W-1:0] angle_in,
    input  wire logic signed [IN_W-1:0]  x_in,
    input  wire logic signed [IN_W-1:0]  y_in,
    output logic                         out_vld,
    output crvu_item_t                   out_item
);

    logic                    a_vld_reg;
    logic                    a_func_reg;
    logic signed [ANG_W-1:0] a_r_reg;
    logic signed [IN_W-1:0]  a_x_reg;
    logic signed [IN_W-1:0]  a_y_reg;
    logic signed [WRAP_W-1:0] sum;
    logic signed [WRAP_W-1:0] r_next;

    logic                    b_vld_reg;
    crvu_item_t              b_item_reg;
    crvu_item_t              b_item_next;
    logic signed [ANG_W-1:0] z_cent;

    // The angle plus pi lies above minus 2pi and below 4pi, so one
    // correction brings it into [0, 2pi).
    always_comb
    begin
        sum = WRAP_W'(angle_in) + PI_WRAP;
        if (sum < 0)
        begin
            r_next = sum + TWO_PI_WRAP;
        end
        else if (sum >= TWO_PI_WRAP)
        begin
            r_next = sum - TWO_PI_WRAP;
        end
        else
        begin
            r_next = sum;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_vld_reg <= 1'b0;
            b_vld_reg <= 1'b0;
        end
        else if (advance)
        begin
            a_vld_reg <= in_vld;
            b_vld_reg <= a_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            a_func_reg <= func;
            a_r_reg    <= r_next[ANG_W-1:0];
            a_x_reg    <= x_in;
            a_y_reg    <= y_in;
            b_item_reg <= b_item_next;
        end
    end

    // In rotation mode, fold into [-pi/2, pi/2]; a half-turn shift is undone by negating
    // both results at the end.
    always_comb
    begin
        z_cent      = a_r_reg - PI_Q28;
        b_item_next = '0;
        if (a_func_reg == FUNC_VECTOR)
        begin
            b_item_next.func = FUNC_VECTOR;
            b_item_next.x    = XY_W'(a_x_reg);
            b_item_next.y    = XY_W'(a_y_reg);
        end
        else
        begin
            b_item_next.x = ONE_Q30;
            if (z_cent < -HALF_PI_Q28)
            begin
                b_item_next.z   = z_cent + PI_Q28;
                b_item_next.neg = 1'b1;
            end
            else if (z_cent > HALF_PI_Q28)
            begin
                b_item_next.z   = z_cent - PI_Q28;
                b_item_next.neg = 1'b1;
            end
            else
            begin
                b_item_next.z = z_cent;
            end
        end
    end

    assign out_vld  = b_vld_reg;
    assign out_item = b_item_reg;

endmodule

`default_nettype wire

/* rtl/crvu_core.sv */
`default_nettype none

module crvu_core
    import crvu_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  advance,
    input  wire logic  in_vld,
    input  crvu_item_t in_item,
    output logic       out_vld,
    output crvu_item_t out_item
);

    logic       vld_reg  [NUM_ITER];
    crvu_item_t pipe_reg [NUM_ITER];

    for (genvar gi = 0; gi < NUM_ITER; gi++)
    begin : g_iter
        logic                    src_vld;
        crvu_item_t              src;
        crvu_item_t              iter_next;
        logic                    sub;
        logic signed [XY_W-1:0]  xs;
        logic signed [XY_W-1:0]  ys;
        logic signed [ANG_W-1:0] at;

        if (gi == 0)
        begin : g_first
            assign src_vld = in_vld;
            assign src     = in_item;
        end
        else
        begin : g_rest
            assign src_vld = vld_reg[gi-1];
            assign src     = pipe_reg[gi-1];
        end

        assign at = atan_entry(gi);

        // Rotation turns toward z = 0, vectoring toward y = 0.
        always_comb
        begin
            xs        = $signed(src.x) >>> gi;
            ys        = $signed(src.y) >>> gi;
            sub       = src.func ? src.y[XY_W-1] : !src.z[ANG_W-1];
            iter_next = src;
            if (sub)
            begin
                iter_next.x = src.x - ys;
                iter_next.y = src.y + xs;
                iter_next.z = src.z - at;
            end
            else
            begin
                iter_next.x = src.x + ys;
                iter_next.y = src.y - xs;
                iter_next.z = src.z + at;
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[gi] <= 1'b0;
            end
            else if (advance)
            begin
                vld_reg[gi] <= src_vld;
            end
        end

        always_ff @(posedge clk)
        begin
            if (advance)
            begin
                pipe_reg[gi] <= iter_next;
            end
        end
    end

    assign out_vld  = vld_reg[NUM_ITER-1];
    assign out_item = pipe_reg[NUM_ITER-1];

endmodule

`default_nettype wire

/* rtl/crvu_scale.sv */
`default_nettype none

module crvu_scale
    import crvu_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    advance,
    input  wire logic    in_vld,
    input  crvu_item_t   in_item,
    output logic         res_vld,
    output crvu_result_t res
);

    logic                     vld_reg;
    logic                     func_reg;
    logic                     neg_reg;
    logic signed [ANG_W-1:0]  z_reg;
    logic signed [PROD_W-1:0] prod_x_reg;
    logic signed [PROD_W-1:0] prod_y_reg;
    logic signed [PROD_W-1:0] prod_x_next;
    logic signed [PROD_W-1:0] prod_y_next;
    logic signed [OUT_W-1:0]  x_fin;
    logic signed [OUT_W-1:0]  y_fin;

    // Round half up to Q2.30 and saturate to the output width.
    function automatic logic signed [OUT_W-1:0] round_sat(input logic signed [PROD_W-1:0] p);
        logic signed [PROD_W-1:0]   rnd;
        logic signed [SH_W-1:0]     sh;
        logic        [SH_W-OUT_W:0] hi;
        logic signed [OUT_W-1:0]    v;
        rnd = p + HALF_ULP;
        sh  = rnd[PROD_W-1:FRAC_XY];
        hi  = sh[SH_W-1:OUT_W-1];
        if ((hi == '0) || (hi == '1))
        begin
            v = sh[OUT_W-1:0];
        end
        else if (sh[SH_W-1])
        begin
            v = {1'b1, {(OUT_W-1){1'b0}}};
        end
        else
        begin
            v = {1'b0, {(OUT_W-1){1'b1}}};
        end
        return v;
    endfunction

    always_comb
    begin
        prod_x_next = in_item.x * GAIN_Q30;
        prod_y_next = in_item.y * GAIN_Q30;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else if (advance)
        begin
            vld_reg <= in_vld;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            func_reg   <= in_item.func;
            neg_reg    <= in_item.neg;
            z_reg      <= in_item.z;
            prod_x_reg <= prod_x_next;
            prod_y_reg <= prod_y_next;
        end
    end

    always_comb
    begin
        x_fin = round_sat(prod_x_reg);
        y_fin = round_sat(prod_y_reg);
        res   = '0;
        if (func_reg)
        begin
            res.magnitude = x_fin;
            res.angle_out = z_reg;
        end
        else if (neg_reg)
        begin
            res.sine   = -y_fin;
            res.cosine = -x_fin;
        end
        else
        begin
            res.sine   = y_fin;
            res.cosine = x_fin;
        end
    end

    assign res_vld = vld_reg;

endmodule

`default_nettype wire

/* rtl/cordic_rotate_vector_unit.sv */
// Pipelined circular CORDIC unit, rotation and vectoring.
// Input channel: in_valid, in_stall and the word func, angle_in, x_in, y_in.
// With func low the word is an angle in Q4.28 radians and the result word
// carries its sine and cosine in Q2.30; with func high it is a vector in
// Q1.30 and the result carries the gain-corrected magnitude (Q2.30) and
// the angle (Q4.28). Fields that do not belong to the mode read as zero.
// Output channel: out_valid, out_stall and sine, cosine, magnitude, angle_out.
// A word is taken at every edge where its valid is high and its stall low.
// Throughput is one word per cycle while in_stall is low. A word passes
// through two angle preparation stages, one stage per micro-rotation,
// one multiplier stage for the gain and the output register.
// When out_stall holds the output word, a skid register takes the next
// result; only once it is full does the whole pipeline freeze and in_stall
// rise, and nothing in flight is lost or repeated.
// Reset clears every valid bit; the unit is ready at once after reset.
`default_nettype none

module cordic_rotate_vector_unit
    import crvu_pkg::*;
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    in_valid,
    output logic                         in_stall,
    input  wire logic                    func,
    input  wire logic signed [ANG_W-1:0] angle_in,
    input  wire logic signed [IN_W-1:0]  x_in,
    input  wire logic signed [IN_W-1:0]  y_in,
    output logic                         out_valid,
    input  wire logic                    out_stall,
    output logic signed [OUT_W-1:0]      sine,
    output logic signed [OUT_W-1:0]      cosine,
    output logic signed [OUT_W-1:0]      magnitude,
    output logic signed [ANG_W-1:0]      angle_out
);

    logic         advance;
    logic         prep_vld;
    crvu_item_t   prep_item;
    logic         core_vld;
    crvu_item_t   core_item;
    logic         res_vld;
    crvu_result_t res;

    logic         out_valid_reg;
    logic         skid_valid_reg;
    crvu_result_t out_reg;
    crvu_result_t skid_reg;

    assign advance  = !skid_valid_reg;
    assign in_stall = skid_valid_reg;

    crvu_prep u_prep (
        .clk      (clk),
        .rst_n    (rst_n),
        .advance  (advance),
        .in_vld   (in_valid),
        .func     (func),
        .angle_in (angle_in),
        .x_in     (x_in),
        .y_in     (y_in),
        .out_vld  (prep_vld),
        .out_item (prep_item)
    );

    crvu_core u_core (
        .clk      (clk),
        .rst_n    (rst_n),
        .advance  (advance),
        .in_vld   (prep_vld),
        .in_item  (prep_item),
        .out_vld  (core_vld),
        .out_item (core_item)
    );

    crvu_scale u_scale (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .in_vld  (core_vld),
        .in_item (core_item),
        .res_vld (res_vld),
        .res     (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (!skid_valid_reg)
        begin
            if (out_valid_reg && out_stall)
            begin
                skid_valid_reg <= res_vld;
            end
            else
            begin
                out_valid_reg <= res_vld;
            end
        end
        else if (!out_stall)
        begin
            skid_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!skid_valid_reg)
        begin
            if (out_valid_reg && out_stall)
            begin
                skid_reg <= res;
            end
            else
            begin
                out_reg <= res;
            end
        end
        else if (!out_stall)
        begin
            out_reg <= skid_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign sine      = out_reg.sine;
    assign cosine    = out_reg.cosine;
    assign magnitude = out_reg.magnitude;
    assign angle_out = out_reg.angle_out;

    a_skid_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid register holds a word while the output is empty");

    a_skid_drains: assert property (@(posedge clk) disable iff (!rst_n)
        (skid_valid_reg && !out_stall) |=> !skid_valid_reg)
        else $error("skid register did not drain after the output was taken");

    a_mode_fields: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ((magnitude == '0 && angle_out == '0) || (sine == '0 && cosine == '0)))
        else $error("result word mixes rotation and vectoring fields");

endmodule

`default_nettype wire
